// ===== hw/rtl/gda_pkg.sv =====
package gda_pkg;

    // Width of the year fields on the ports.
    localparam int YEAR_PORT_W = 16;

    // Remainder of the year by 400 fits in nine bits.
    localparam int REM_W = 9;
    localparam logic [REM_W:0] LEAP_CYCLE = 10'd400;
    localparam logic [REM_W-1:0] LAST_REM = 9'd399;

    // Reciprocal of 25 scaled by 2^33, rounded up; exact for any 28-bit dividend.
    localparam logic [28:0] RECIP_25 = 29'd343597384;
    localparam int RECIP_SHIFT = 33;

    // Operation codes.
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_ADVANCE = 2'd1;
    localparam logic [1:0] OP_COMPARE = 2'd2;

    // Month numbers and lengths.
    localparam logic [3:0] MONTH_FIRST = 4'd1;
    localparam logic [3:0] MONTH_LAST  = 4'd12;
    localparam logic [3:0] MONTH_FEB   = 4'd2;
    localparam logic [4:0] DAY_FIRST   = 5'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_CHECK,
        S_ADV,
        S_DONE
    } t_state;

    // Status from the remainder unit.
    typedef struct packed {
        logic             done;
        logic [REM_W-1:0] rem;
    } t_mod_rsp;

    // Leap rule on the year modulo 400: divisible by 4, and century
    // years only when divisible by 400.
    function automatic logic is_leap(input logic [REM_W-1:0] rem);
        logic century;
        century = (rem == 9'd100) || (rem == 9'd200) || (rem == 9'd300);
        return (rem == 9'd0) || ((rem[1:0] == 2'b00) && !century);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] month,
                                             input logic leap);
        logic [4:0] len;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            default:                                    len = leap ? 5'd29 : 5'd28;
        endcase
        return len;
    endfunction

endpackage

// ===== hw/rtl/gda_if.sv =====
// Request channel: one beat carries one operation.
interface gda_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [4:0]  day_in;
    logic [3:0]  month_in;
    logic [15:0] year_in;
    logic [15:0] day_count;

    modport source (output valid, operation, day_in, month_in, year_in, day_count,
                    input ready);
    modport sink (input valid, operation, day_in, month_in, year_in, day_count,
                  output ready);
endinterface

// Result channel: one beat per operation.
interface gda_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  day_out;
    logic [3:0]  month_out;
    logic [15:0] year_out;
    logic        load_ok;
    logic        dates_equal;

    modport source (output valid, day_out, month_out, year_out, load_ok, dates_equal,
                    input ready);
    modport sink (input valid, day_out, month_out, year_out, load_ok, dates_equal,
                  output ready);
endinterface

// ===== hw/rtl/gda_mod400.sv =====
// Remainder of a year by 400 in registered steps. The quotient by 400 is
// the year over 16 times the scaled reciprocal of 25; the remainder is the
// year less 400 times that quotient, which only needs the low nine bits.
// The start pulse latches the year; the quotient, then the remainder follow.
module gda_mod400 import gda_pkg::*; #(
    parameter int YEAR_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [YEAR_WIDTH-1:0] i_year,
    output t_mod_rsp              o_rsp
);
    logic             r_mul, n_mul;
    logic             r_sub, n_sub;
    logic             r_done, n_done;
    logic [31:0]      r_year, n_year;
    logic [REM_W-1:0] r_quot, n_quot;
    logic [REM_W-1:0] r_rem, n_rem;
    logic [27:0]      year_div16;
    logic [56:0]      product;
    logic [REM_W-1:0] quot_x400;

    // Quotient by 400 from the reciprocal, then the remainder modulo 512.
    assign year_div16 = r_year[31:4];
    assign product    = {29'd0, year_div16} * {28'd0, RECIP_25};
    assign quot_x400  = r_quot * LEAP_CYCLE[REM_W-1:0];

    // Step sequencer: latch the year, take the quotient, then the remainder.
    always_comb begin
        n_mul  = 1'b0;
        n_sub  = 1'b0;
        n_done = 1'b0;
        n_year = r_year;
        n_quot = r_quot;
        n_rem  = r_rem;
        if (i_start) begin
            n_mul  = 1'b1;
            n_year = 32'(i_year);
        end else if (r_mul) begin
            n_sub  = 1'b1;
            n_quot = product[RECIP_SHIFT +: REM_W];
        end else if (r_sub) begin
            n_done = 1'b1;
            n_rem  = r_year[REM_W-1:0] - quot_x400;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul  <= 1'b0;
            r_sub  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_mul  <= n_mul;
            r_sub  <= n_sub;
            r_done <= n_done;
        end
        r_year <= n_year;
        r_quot <= n_quot;
        r_rem  <= n_rem;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

// ===== hw/rtl/gregorian_date_advancer_unit.sv =====
// Gregorian date counter. It holds one date and serves load, advance and
// compare beats, each answered by exactly one result beat showing the stored
// date. Load and compare check the given date first; the leap test needs the
// year modulo 400, which a reciprocal remainder unit produces, so such a beat
// passes through S_MOD, which waits for the remainder, and S_CHECK before
// S_DONE loads the result register. Advance runs through a month-stepping
// loop in S_ADV that consumes the rest of the current month per cycle and
// crosses k month ends (about 2155 at most for a count of 65535). An advance
// by zero and the unused operation code go straight to S_DONE. A result that
// waits for the receiver holds the block in its final state until the output
// register frees up. The block takes one beat at a time; a new beat is
// accepted while an earlier result still waits in the output register.
module gregorian_date_advancer_unit import gda_pkg::*; #(
    parameter int YEAR_WIDTH = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    gda_in_if.sink    i_in,
    gda_out_if.source o_out
);
    t_state r_state, n_state;

    // Latched request.
    logic [1:0]            r_op, n_op;
    logic [4:0]            r_d, n_d;
    logic [3:0]            r_m, n_m;
    logic [YEAR_WIDTH-1:0] r_y, n_y;
    logic [15:0]           r_n, n_n;

    // Stored date and its year modulo 400.
    logic [4:0]            r_cur_day, n_cur_day;
    logic [3:0]            r_cur_month, n_cur_month;
    logic [YEAR_WIDTH-1:0] r_cur_year, n_cur_year;
    logic [REM_W-1:0]      r_cur_rem, n_cur_rem;

    logic r_ok, n_ok;
    logic r_eq, n_eq;

    // Output register.
    logic                   r_out_valid, n_out_valid;
    logic [4:0]             r_out_day, n_out_day;
    logic [3:0]             r_out_month, n_out_month;
    logic [YEAR_PORT_W-1:0] r_out_year, n_out_year;
    logic                   r_out_ok, n_out_ok;
    logic                   r_out_eq, n_out_eq;

    logic                  in_fire;
    logic                  mod_start;
    logic [31:0]           year_in_wide;
    logic [31:0]           year_out_wide;
    logic [YEAR_WIDTH-1:0] in_year;
    t_mod_rsp              mod_rsp;
    logic [4:0]            chk_len;
    logic                  chk_valid;
    logic [4:0]            cur_len;
    logic [4:0]            days_left;
    logic                  out_free;

    assign in_fire       = i_in.valid && i_in.ready;
    assign i_in.ready    = (r_state == S_IDLE);
    assign year_in_wide  = {16'd0, i_in.year_in};
    assign in_year       = year_in_wide[YEAR_WIDTH-1:0];
    assign year_out_wide = 32'(r_cur_year);
    assign out_free      = !r_out_valid || o_out.ready;
    assign mod_start     = in_fire && (i_in.operation == OP_LOAD ||
                                       i_in.operation == OP_COMPARE);

    gda_mod400 #(.YEAR_WIDTH(YEAR_WIDTH)) u_mod400 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_year  (in_year),
        .o_rsp   (mod_rsp)
    );

    // Check of the request date and the days left in the current month.
    assign chk_len   = month_len(r_m, is_leap(mod_rsp.rem));
    assign chk_valid = (r_m >= MONTH_FIRST) && (r_m <= MONTH_LAST) &&
                       (r_d != 5'd0) && (r_d <= chk_len);
    assign cur_len   = month_len(r_cur_month, is_leap(r_cur_rem));
    assign days_left = cur_len - r_cur_day;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in.operation == OP_LOAD || i_in.operation == OP_COMPARE) begin
                        n_state = S_MOD;
                    end else if (i_in.operation == OP_ADVANCE && i_in.day_count != 16'd0) begin
                        n_state = S_ADV;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_MOD: begin
                if (mod_rsp.done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: n_state = S_DONE;
            S_ADV: begin
                if (r_n <= 16'(days_left)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and result register.
    always_comb begin
        n_op        = r_op;
        n_d         = r_d;
        n_m         = r_m;
        n_y         = r_y;
        n_n         = r_n;
        n_cur_day   = r_cur_day;
        n_cur_month = r_cur_month;
        n_cur_year  = r_cur_year;
        n_cur_rem   = r_cur_rem;
        n_ok        = r_ok;
        n_eq        = r_eq;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_day   = r_out_day;
        n_out_month = r_out_month;
        n_out_year  = r_out_year;
        n_out_ok    = r_out_ok;
        n_out_eq    = r_out_eq;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_op = i_in.operation;
                    n_d  = i_in.day_in;
                    n_m  = i_in.month_in;
                    n_y  = in_year;
                    n_n  = i_in.day_count;
                    n_ok = 1'b0;
                    n_eq = 1'b0;
                end
            end
            S_CHECK: begin
                // An invalid date stands as 1/1/1.
                if (r_op == OP_LOAD) begin
                    n_ok = chk_valid;
                    if (chk_valid) begin
                        n_cur_day   = r_d;
                        n_cur_month = r_m;
                        n_cur_year  = r_y;
                        n_cur_rem   = mod_rsp.rem;
                    end else begin
                        n_cur_day   = DAY_FIRST;
                        n_cur_month = MONTH_FIRST;
                        n_cur_year  = YEAR_WIDTH'(1);
                        n_cur_rem   = REM_W'(1);
                    end
                end else if (chk_valid) begin
                    n_eq = (r_d == r_cur_day) && (r_m == r_cur_month) && (r_y == r_cur_year);
                end else begin
                    n_eq = (r_cur_day == DAY_FIRST) && (r_cur_month == MONTH_FIRST) &&
                           (r_cur_year == YEAR_WIDTH'(1));
                end
            end
            S_ADV: begin
                // Either finish inside this month or jump to the first of the next.
                if (r_n <= 16'(days_left)) begin
                    n_cur_day = r_cur_day + r_n[4:0];
                    n_n       = '0;
                end else begin
                    n_n       = r_n - 16'(days_left) - 16'd1;
                    n_cur_day = DAY_FIRST;
                    if (r_cur_month == MONTH_LAST) begin
                        n_cur_month = MONTH_FIRST;
                        n_cur_year  = r_cur_year + 1'b1;
                        // The year wraps to zero, which is a multiple of 400.
                        if (&r_cur_year || r_cur_rem == LAST_REM) begin
                            n_cur_rem = '0;
                        end else begin
                            n_cur_rem = r_cur_rem + 1'b1;
                        end
                    end else begin
                        n_cur_month = r_cur_month + 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_day   = r_cur_day;
                    n_out_month = r_cur_month;
                    n_out_year  = year_out_wide[YEAR_PORT_W-1:0];
                    n_out_ok    = r_ok;
                    n_out_eq    = r_eq;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cur_day   <= DAY_FIRST;
            r_cur_month <= MONTH_FIRST;
            r_cur_year  <= YEAR_WIDTH'(1);
            r_cur_rem   <= REM_W'(1);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cur_day   <= n_cur_day;
            r_cur_month <= n_cur_month;
            r_cur_year  <= n_cur_year;
            r_cur_rem   <= n_cur_rem;
        end
        r_op        <= n_op;
        r_d         <= n_d;
        r_m         <= n_m;
        r_y         <= n_y;
        r_n         <= n_n;
        r_ok        <= n_ok;
        r_eq        <= n_eq;
        r_out_day   <= n_out_day;
        r_out_month <= n_out_month;
        r_out_year  <= n_out_year;
        r_out_ok    <= n_out_ok;
        r_out_eq    <= n_out_eq;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.day_out     = r_out_day;
    assign o_out.month_out   = r_out_month;
    assign o_out.year_out    = r_out_year;
    assign o_out.load_ok     = r_out_ok;
    assign o_out.dates_equal = r_out_eq;

`ifndef SYNTHESIS
    // The stored date is always a real calendar date.
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_month >= MONTH_FIRST && r_cur_month <= MONTH_LAST)
        else $error("stored month out of range");

    a_day_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_day != 5'd0 && r_cur_day <= cur_len)
        else $error("stored day outside its month");

    // The tracked remainder stays below 400.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_rem <= LAST_REM)
        else $error("year remainder out of range");

    // The remainder unit only finishes while the sequencer waits for it.
    a_mod_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_rsp.done |-> r_state == S_MOD)
        else $error("remainder finished outside its wait state");
`endif

endmodule
